// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SCD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo chorus package
// Fixed widths, register indexes, reset values and helper functions.
// ----------------------------------------------------------------------------
package scd_pkg;

  typedef logic signed [15:0] sample_t;

  // Register indexes
  localparam logic [2:0] REG_BYPASS     = 3'd0;
  localparam logic [2:0] REG_PHASE_STEP = 3'd1;
  localparam logic [2:0] REG_BASE_DELAY = 3'd2;
  localparam logic [2:0] REG_MOD_DEPTH  = 3'd3;
  localparam logic [2:0] REG_WET_LEVEL  = 3'd4;
  localparam logic [2:0] REG_FEEDBACK   = 3'd5;

  // Reset values
  localparam logic [15:0] RST_PHASE_STEP = 16'd55;
  localparam logic [17:0] RST_BASE_DELAY = 18'd122880;
  localparam logic [15:0] RST_MOD_DEPTH  = 16'd30720;
  localparam logic [15:0] RST_WET_LEVEL  = 16'd16384;

  localparam logic [15:0] UNITY_Q15      = 16'd32768;
  localparam logic [15:0] RIGHT_OFFSET   = 16'd8192;   // 45 degrees ahead

  // Shared serial multiplier: 18 x 18 signed, one multiplier bit per cycle
  localparam int unsigned MUL_W     = 18;
  localparam int unsigned ACC_W     = 2 * MUL_W;
  localparam int unsigned MUL_STEPS = MUL_W;

  // Quarter-wave sine generation (elaboration only)
  localparam logic [63:0] Q30_ONE    = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Series sine of angle x (Q30 radians), scaled to 32767 and rounded
  function automatic logic [14:0] sine_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] r;
    x2 = (x * x) >> 30;
    a  = Q30_ONE - x2 / 64'd72;
    a  = Q30_ONE - ((x2 * a) >> 30) / 64'd42;
    a  = Q30_ONE - ((x2 * a) >> 30) / 64'd20;
    a  = Q30_ONE - ((x2 * a) >> 30) / 64'd6;
    s  = (x * a) >> 30;
    r  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    return r[14:0];
  endfunction

  // Saturate to a 16-bit signed sample
  function automatic sample_t sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      return 16'sh7fff;
    end else if (v < -20'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

// ===== rtl/core/stereo_chorus_delay_core.sv =====
// ----------------------------------------------------------------------------
// Stereo chorus delay core
// Mono in, stereo out chorus with two modulated, interpolated delay rings.
// ----------------------------------------------------------------------------
// One item in, one stereo item out. All products go through a single
// bit-serial 18 x 18 multiplier, which is loaded before each product. An
// item needs eleven products: one dry product, then five per channel (sine
// times depth, two interpolation weights, feedback and wet mix). The next
// item is not taken until the current one has left through the output step;
// in bypass no products are run. Ring reads go through one registered read
// port per channel. After reset a clearing pass zeroes every entry of both
// rings; no item is accepted until it ends. A finished result sits in the
// output register while the next item is accepted.

`include "assert_macros.svh"

module stereo_chorus_delay_core #(
  parameter int unsigned RING_DEPTH       = 1024,
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    in_sample_in,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_left_out,
  output logic signed [15:0]    out_right_out,
  // configuration
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [17:0]           cfg_data
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned PW = AW + 8;
  localparam int unsigned CW = (PW > 21) ? PW + 1 : 22;
  localparam int unsigned SB = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned MW = scd_pkg::MUL_W;
  localparam int unsigned AC = scd_pkg::ACC_W;

  // Sequencer states
  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_DRY  = 4'd2;
  localparam logic [3:0] ST_SIN  = 4'd3;
  localparam logic [3:0] ST_ADR  = 4'd4;
  localparam logic [3:0] ST_RD1  = 4'd5;
  localparam logic [3:0] ST_W1   = 4'd6;
  localparam logic [3:0] ST_W2   = 4'd7;
  localparam logic [3:0] ST_FB   = 4'd8;
  localparam logic [3:0] ST_MIX  = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  // Quarter-wave sine table
  logic [14:0] sine_tab [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
    localparam logic [63:0] ANGLE = (64'(k) * scd_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    assign sine_tab[k] = scd_pkg::sine_entry(ANGLE);
  end

  // Configuration registers
  logic                 cfg_bypass_r;
  logic [15:0]          cfg_phase_step_r;
  logic [17:0]          cfg_base_delay_r;
  logic [15:0]          cfg_mod_depth_r;
  logic [15:0]          cfg_wet_level_r;
  logic signed [15:0]   cfg_feedback_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_bypass_r     <= 1'b0;
      cfg_phase_step_r <= scd_pkg::RST_PHASE_STEP;
      cfg_base_delay_r <= scd_pkg::RST_BASE_DELAY;
      cfg_mod_depth_r  <= scd_pkg::RST_MOD_DEPTH;
      cfg_wet_level_r  <= scd_pkg::RST_WET_LEVEL;
      cfg_feedback_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        scd_pkg::REG_BYPASS:     cfg_bypass_r     <= cfg_data[0];
        scd_pkg::REG_PHASE_STEP: cfg_phase_step_r <= cfg_data[15:0];
        scd_pkg::REG_BASE_DELAY: cfg_base_delay_r <= cfg_data;
        scd_pkg::REG_MOD_DEPTH:  cfg_mod_depth_r  <= cfg_data[15:0];
        scd_pkg::REG_WET_LEVEL:  cfg_wet_level_r  <= cfg_data[15:0];
        scd_pkg::REG_FEEDBACK:   cfg_feedback_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // State and datapath registers
  logic [3:0]            state_r, state_nxt;
  logic                  ch_r, ch_nxt;
  logic                  byp_r, byp_nxt;
  scd_pkg::sample_t      x_r, x_nxt;
  logic [AW-1:0]         wp_r, wp_nxt;
  logic [15:0]           phase_r, phase_nxt;
  logic [AW-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic signed [31:0]    dryx_r, dryx_nxt;
  logic signed [25:0]    sum_r, sum_nxt;
  scd_pkg::sample_t      tap_r, tap_nxt;
  logic [AW-1:0]         i1_r, i1_nxt;
  logic [7:0]            frac_r, frac_nxt;
  scd_pkg::sample_t      lres_r, lres_nxt;
  scd_pkg::sample_t      rres_r, rres_nxt;
  scd_pkg::sample_t      out_left_r, out_left_nxt;
  scd_pkg::sample_t      out_right_r, out_right_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Serial multiplier registers
  logic signed [MW-1:0]  mul_a_r, mul_a_nxt;
  logic [MW-1:0]         mul_b_r, mul_b_nxt;
  logic [4:0]            mul_cnt_r, mul_cnt_nxt;
  logic                  mul_busy_r, mul_busy_nxt;
  logic signed [AC-1:0]  acc_r, acc_nxt;

  // Ring ports
  logic                  we_left, we_right;
  logic [AW-1:0]         ring_waddr;
  scd_pkg::sample_t      ring_wdata;
  logic [AW-1:0]         rd_addr;
  scd_pkg::sample_t      rd_left_r, rd_right_r, rd_q;

  scd_pkg::sample_t      left_ring  [RING_DEPTH];
  scd_pkg::sample_t      right_ring [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we_left) begin
      left_ring[ring_waddr] <= ring_wdata;
    end
    rd_left_r <= left_ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_right) begin
      right_ring[ring_waddr] <= ring_wdata;
    end
    rd_right_r <= right_ring[rd_addr];
  end

  assign rd_q = ch_r ? rd_right_r : rd_left_r;

  // Multiplier step: MSB first, sign bit weighted negative
  logic signed [AC-1:0]  mul_addend;
  logic signed [AC-1:0]  acc_step;
  logic                  mul_last;

  always_comb begin
    mul_addend = mul_b_r[MW-1] ? AC'(mul_a_r) : '0;
    acc_step   = (mul_cnt_r == '0) ? -mul_addend : ((acc_r <<< 1) + mul_addend);
    mul_last   = mul_busy_r && (mul_cnt_r == 5'(scd_pkg::MUL_STEPS - 1));
  end

  // Sine of the current channel's phase
  logic [15:0]           ph;
  logic [14:0]           qpos;
  logic [14:0]           mag;
  logic signed [16:0]    sine_val;

  always_comb begin
    ph       = ch_r ? (phase_r + scd_pkg::RIGHT_OFFSET) : phase_r;
    qpos     = ph[14] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    mag      = qpos[14] ? 15'd32767 : sine_tab[qpos[13 -: SB]];
    sine_val = ph[15] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  end

  // Gains and combinational helpers
  logic [15:0]           wet_c, dry_c;
  logic signed [CW-1:0]  delay;
  logic [CW-1:0]         pos_full;
  logic signed [25:0]    mix_sum;
  logic signed [17:0]    fb_sum;
  logic signed [33:0]    out_sum;

  always_comb begin
    wet_c    = (cfg_wet_level_r > scd_pkg::UNITY_Q15) ? scd_pkg::UNITY_Q15 : cfg_wet_level_r;
    dry_c    = scd_pkg::UNITY_Q15 - wet_c;
    delay    = $signed(CW'(cfg_base_delay_r)) + CW'(acc_r[AC-1:15]);
    pos_full = CW'({wp_r, 8'd0}) - $unsigned(delay);
    mix_sum  = sum_r + acc_r[25:0];
    fb_sum   = 18'(x_r) + 18'($signed(acc_r[31:15]));
    out_sum  = 34'(dryx_r) + acc_r[33:0];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    byp_nxt       = byp_r;
    x_nxt         = x_r;
    wp_nxt        = wp_r;
    phase_nxt     = phase_r;
    clr_cnt_nxt   = clr_cnt_r;
    dryx_nxt      = dryx_r;
    sum_nxt       = sum_r;
    tap_nxt       = tap_r;
    i1_nxt        = i1_r;
    frac_nxt      = frac_r;
    lres_nxt      = lres_r;
    rres_nxt      = rres_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    mul_cnt_nxt   = mul_cnt_r;
    mul_busy_nxt  = mul_busy_r;
    acc_nxt       = acc_r;
    we_left       = 1'b0;
    we_right      = 1'b0;
    ring_waddr    = wp_r;
    ring_wdata    = '0;
    rd_addr       = i1_r;

    // multiplier runs whenever it is busy
    if (mul_busy_r) begin
      acc_nxt     = acc_step;
      mul_b_nxt   = {mul_b_r[MW-2:0], 1'b0};
      mul_cnt_nxt = mul_cnt_r + 5'd1;
      if (mul_last) begin
        mul_busy_nxt = 1'b0;
      end
    end

    case (state_r)
      ST_CLR: begin
        we_left     = 1'b1;
        we_right    = 1'b1;
        ring_waddr  = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(RING_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          x_nxt   = in_sample_in;
          byp_nxt = cfg_bypass_r;
          ch_nxt  = 1'b0;
          if (cfg_bypass_r) begin
            lres_nxt  = in_sample_in;
            rres_nxt  = in_sample_in;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_DRY;
          end
        end
      end
      ST_DRY: begin
        if (!mul_busy_r) begin
          mul_a_nxt    = $signed(MW'(dry_c));
          mul_b_nxt    = MW'(x_r);
          mul_cnt_nxt  = '0;
          mul_busy_nxt = 1'b1;
        end else if (mul_last) begin
          state_nxt = ST_SIN;
        end
      end
      ST_SIN: begin
        if (!mul_busy_r) begin
          if (!ch_r) begin
            dryx_nxt = acc_r[31:0];
          end
          mul_a_nxt    = MW'(sine_val);
          mul_b_nxt    = MW'(cfg_mod_depth_r);
          mul_cnt_nxt  = '0;
          mul_busy_nxt = 1'b1;
        end else if (mul_last) begin
          state_nxt = ST_ADR;
        end
      end
      ST_ADR: begin
        // read position behind the write pointer
        i1_nxt    = pos_full[PW-1:8];
        frac_nxt  = pos_full[7:0];
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        rd_addr   = i1_r;
        state_nxt = ST_W1;
      end
      ST_W1: begin
        rd_addr = i1_r + 1'b1;
        if (!mul_busy_r) begin
          mul_a_nxt    = MW'(rd_q);
          mul_b_nxt    = MW'(9'd256 - {1'b0, frac_r});
          mul_cnt_nxt  = '0;
          mul_busy_nxt = 1'b1;
        end else if (mul_last) begin
          state_nxt = ST_W2;
        end
      end
      ST_W2: begin
        rd_addr = i1_r + 1'b1;
        if (!mul_busy_r) begin
          sum_nxt      = acc_r[25:0];
          mul_a_nxt    = MW'(rd_q);
          mul_b_nxt    = MW'(frac_r);
          mul_cnt_nxt  = '0;
          mul_busy_nxt = 1'b1;
        end else if (mul_last) begin
          state_nxt = ST_FB;
        end
      end
      ST_FB: begin
        if (!mul_busy_r) begin
          tap_nxt      = mix_sum[23:8];
          mul_a_nxt    = MW'($signed(mix_sum[23:8]));
          mul_b_nxt    = MW'(cfg_feedback_r);
          mul_cnt_nxt  = '0;
          mul_busy_nxt = 1'b1;
        end else if (mul_last) begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        if (!mul_busy_r) begin
          // ring write: input plus fed-back delayed sample
          ring_wdata   = scd_pkg::sat16(20'(fb_sum));
          we_left      = !ch_r;
          we_right     = ch_r;
          mul_a_nxt    = $signed(MW'(wet_c));
          mul_b_nxt    = MW'(tap_r);
          mul_cnt_nxt  = '0;
          mul_busy_nxt = 1'b1;
        end else if (mul_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!ch_r) begin
          lres_nxt  = scd_pkg::sat16(20'($signed(out_sum[33:15])));
          ch_nxt    = 1'b1;
          state_nxt = ST_SIN;
        end else begin
          rres_nxt  = scd_pkg::sat16(20'($signed(out_sum[33:15])));
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_left_nxt  = lres_r;
          out_right_nxt = rres_r;
          out_valid_nxt = 1'b1;
          if (!byp_r) begin
            wp_nxt    = wp_r + 1'b1;
            phase_nxt = phase_r + cfg_phase_step_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      wp_r        <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      mul_busy_r  <= 1'b0;
      ch_r        <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      wp_r        <= wp_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      mul_busy_r  <= mul_busy_nxt;
      ch_r        <= ch_nxt;
      byp_r       <= byp_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    dryx_r      <= dryx_nxt;
    sum_r       <= sum_nxt;
    tap_r       <= tap_nxt;
    i1_r        <= i1_nxt;
    frac_r      <= frac_nxt;
    lres_r      <= lres_nxt;
    rres_r      <= rres_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    mul_cnt_r   <= mul_cnt_nxt;
    acc_r       <= acc_nxt;
  end

  // Ports
  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  // Checks
  `SCD_ASSERT_NXT(a_out_from_seq, clk, rst_n, !out_valid_r && state_r != ST_OUT, !out_valid_r, "result item appeared outside the output step")
  `SCD_ASSERT_IMP(a_mul_in_mul_state, clk, rst_n, mul_busy_r, state_r == ST_DRY || state_r == ST_SIN || state_r == ST_W1 || state_r == ST_W2 || state_r == ST_FB || state_r == ST_MIX, "multiplier running outside a product step")
  `SCD_ASSERT_NXT(a_state_frozen_bypass, clk, rst_n, byp_r && state_r == ST_OUT, wp_r == $past(wp_r) && phase_r == $past(phase_r), "bypass item moved ring state")

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Stereo chorus delay core testbench
// Drives mono samples through the chorus with random bursts and output stalls,
// predicts each stereo item from a behavioural model of the delay rings, LFO
// and mixer, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int RING  = 1024;
  localparam int SDEPTH = 256;
  localparam int ITEM_LATENCY = 300;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_sample_in;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_left_out;
  logic signed [15:0] out_right_out;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [17:0] cfg_data;

  stereo_chorus_delay_core dut (.*);

  // Predictor state
  logic signed [15:0] quarter_tab [SDEPTH];
  logic signed [15:0] left_store [RING];
  logic signed [15:0] right_store [RING];
  logic [9:0]  wr_ptr;
  logic [15:0] lfo;
  logic        m_bypass;
  logic [15:0] m_step;
  logic [17:0] m_base;
  logic [15:0] m_depth;
  logic [15:0] m_wet;
  logic signed [15:0] m_fb;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } stereo_t;

  stereo_t expected_q[$];
  int mismatches;
  int results_seen;
  int max_gap;
  int stall_pct;

  // Quarter-wave table from the same integer series
  task automatic build_quarter();
    longint unsigned x, x2, a, s;
    for (int k = 0; k < SDEPTH; k++) begin
      x  = (longint'(k) * 64'd1686629713) / SDEPTH;
      x2 = (x * x) >> 30;
      a  = 64'd1073741824 - x2 / 72;
      a  = 64'd1073741824 - ((x2 * a) >> 30) / 42;
      a  = 64'd1073741824 - ((x2 * a) >> 30) / 20;
      a  = 64'd1073741824 - ((x2 * a) >> 30) / 6;
      s  = (x * a) >> 30;
      quarter_tab[k] = 16'((s * 32767 + 64'd536870912) >> 30);
    end
  endtask

  function automatic longint floor_div(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint quarter_at(int unsigned p);
    int unsigned idx;
    if (p >= 16384) return 32767;
    idx = (p * SDEPTH) >> 14;
    if (idx >= SDEPTH) idx = SDEPTH - 1;
    return quarter_tab[idx];
  endfunction

  function automatic longint lfo_sine(logic [15:0] ph);
    longint m;
    m = ph[14] ? quarter_at(16384 - ph[13:0]) : quarter_at(ph[13:0]);
    return ph[15] ? -m : m;
  endfunction

  // Interpolated read at the modulated delay
  function automatic longint delayed_read(bit right, logic [15:0] ph);
    longint dly, mix, a, b;
    logic [17:0] pos;
    logic [9:0] i1, i2;
    dly = longint'(m_base) + floor_div(lfo_sine(ph) * longint'(m_depth), 15);
    pos = {wr_ptr, 8'd0} - 18'(dly);
    i1 = pos[17:8];
    i2 = i1 + 10'd1;
    a = right ? right_store[i1] : left_store[i1];
    b = right ? right_store[i2] : left_store[i2];
    mix = a * (256 - longint'(pos[7:0])) + b * longint'(pos[7:0]);
    return floor_div(mix, 8);
  endfunction

  function automatic stereo_t chorus_predict(logic signed [15:0] x);
    stereo_t r;
    longint dl, dr, wet, dry;
    if (m_bypass) begin
      r.left = x;
      r.right = x;
      return r;
    end
    dl = delayed_read(0, lfo);
    dr = delayed_read(1, lfo + scd_pkg::RIGHT_OFFSET);
    left_store[wr_ptr]  = 16'(clip16(x + floor_div(dl * m_fb, 15)));
    right_store[wr_ptr] = 16'(clip16(x + floor_div(dr * m_fb, 15)));
    wet = (m_wet > 16'd32768) ? 32768 : m_wet;
    dry = 32768 - wet;
    r.left  = 16'(clip16(floor_div(dry * x + wet * dl, 15)));
    r.right = 16'(clip16(floor_div(dry * x + wet * dr, 15)));
    wr_ptr = wr_ptr + 10'd1;
    lfo = lfo + m_step;
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver stall pattern and result checking
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    stereo_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected item L=%0d R=%0d", out_left_out, out_right_out);
      end else begin
        e = expected_q.pop_front();
        if (e.left !== out_left_out || e.right !== out_right_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: item %0d expected L=%0d R=%0d got L=%0d R=%0d",
                     results_seen, e.left, e.right, out_left_out, out_right_out);
        end
      end
    end
  end

  // Send one sample; random gap before it when a burst ends
  task automatic send_sample(logic signed [15:0] x);
    int gap;
    gap = 0;
    if (max_gap > 0 && $urandom_range(3) == 0) gap = $urandom_range(max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(chorus_predict(x));
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (ITEM_LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [17:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      scd_pkg::REG_BYPASS:     m_bypass = val[0];
      scd_pkg::REG_PHASE_STEP: m_step = val[15:0];
      scd_pkg::REG_BASE_DELAY: m_base = val;
      scd_pkg::REG_MOD_DEPTH:  m_depth = val[15:0];
      scd_pkg::REG_WET_LEVEL:  m_wet = val[15:0];
      scd_pkg::REG_FEEDBACK:   m_fb = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] st, logic [17:0] bd, logic [15:0] md,
                         logic [15:0] wl, logic [15:0] fb);
    write_reg(scd_pkg::REG_PHASE_STEP, st);
    write_reg(scd_pkg::REG_BASE_DELAY, bd);
    write_reg(scd_pkg::REG_MOD_DEPTH, md);
    write_reg(scd_pkg::REG_WET_LEVEL, wl);
    write_reg(scd_pkg::REG_FEEDBACK, fb);
  endtask

  // Field extremes under reset settings, fast LFO and bypass
  task automatic test_directed();
    logic signed [15:0] pts [8] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
                                   16'sh0001, 16'sh5555, 16'shaaaa, 16'sh7fff};
    max_gap = 0;
    stall_pct = 0;
    foreach (pts[i]) send_sample(pts[i]);
    go_idle();
    // short delays read fresh entries; delay zero and wrapped ones
    set_all(16'd16384, 18'd256, 16'd65535, 16'd32768, 16'sh7fff);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7fff);
    go_idle();
    // wet above unity, negative feedback, maximum delay
    set_all(16'd65535, 18'd261888, 16'd0, 16'd65535, 16'sh8000);
    for (int i = 0; i < 4; i++) send_sample(16'($urandom));
    go_idle();
    write_reg(scd_pkg::REG_BYPASS, 18'd1);
    for (int i = 0; i < 4; i++) send_sample(16'($urandom));
    go_idle();
    write_reg(scd_pkg::REG_BYPASS, 18'd0);
    write_reg(3'd7, 18'h3ffff);   // unused index, ignored
    send_sample(16'sh1234);
    go_idle();
  endtask

  // Random settings per phase, random samples with bursts and stalls
  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      set_all(16'($urandom), 18'($urandom_range(18'h3ffff)),
              16'($urandom), 16'($urandom_range(40000)), 16'($urandom));
      if (p % 5 == 4) write_reg(scd_pkg::REG_BYPASS, 18'($urandom_range(1)));
      else write_reg(scd_pkg::REG_BYPASS, 18'd0);
      max_gap = (p % 3 == 0) ? 0 : $urandom_range(40);
      stall_pct = (p % 4 == 0) ? 0 : $urandom_range(80);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(9) == 0)
          send_sample($urandom_range(1) ? 16'sh7fff : 16'sh8000);
        else
          send_sample(16'($urandom));
      end
      go_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = scd_pkg::REG_BYPASS;
    cfg_data = '0;
    mismatches = 0;
    results_seen = 0;
    max_gap = 0;
    stall_pct = 0;
    build_quarter();
    foreach (left_store[i]) begin
      left_store[i] = '0;
      right_store[i] = '0;
    end
    wr_ptr = '0;
    lfo = '0;
    m_bypass = 1'b0;
    m_step = scd_pkg::RST_PHASE_STEP;
    m_base = scd_pkg::RST_BASE_DELAY;
    m_depth = scd_pkg::RST_MOD_DEPTH;
    m_wet = scd_pkg::RST_WET_LEVEL;
    m_fb = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(12, 48);
    $display("Covered %0d stereo items over directed extremes and 12 random settings.",
             results_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit: generous bound on the slowest correct run
  initial begin
    #60000000;
    $display("Timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
